// ----- hw/rtl/tx_trigger_rate_gate_core_macros.svh -----
// Assertion macros for the transmit trigger rate gate, sampled on clk, idle in reset.
`ifndef TX_TRIGGER_RATE_GATE_CORE_MACROS_SVH
`define TX_TRIGGER_RATE_GATE_CORE_MACROS_SVH

// Same-cycle implication.
`define TTRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttrg check failed");

// Next-cycle implication.
`define TTRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttrg check failed");

`endif

// ----- hw/rtl/ttrg_pkg.sv -----
// Types, constants and fire-attempt function for the transmit trigger rate gate.
package ttrg_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int MS_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CYCLE_TIME  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_GAP     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPONT_EN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ONLY_ACTIVE = 8'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SPONT = 1'b1;

  localparam logic KIND_PERIODIC = 1'b0;
  localparam logic KIND_SPONT    = 1'b1;

  localparam logic [1:0] INACTIVE_LIMIT = 2'd1;
  localparam logic [1:0] INACTIVE_SAT   = 2'd2;

  localparam logic [MS_W-1:0] MS_MAX = '1;

  typedef struct packed {
    logic opcode;
    logic all_default;
    logic service_running;
  } in_item_t;

  typedef struct packed {
    logic fire;
    logic fire_kind;
    logic pending;
  } out_item_t;

  typedef struct packed {
    logic [MS_W-1:0] cycle_time_ms;
    logic [MS_W-1:0] min_gap_ms;
    logic            spontaneous_enable;
    logic            send_only_if_active;
  } cfg_t;

  typedef struct packed {
    logic [MS_W-1:0] period_phase;
    logic [MS_W-1:0] since_last_fire;
    logic            deferred_valid;
    logic            deferred_kind;
    logic [1:0]      inactive_count;
  } gate_state_t;

  typedef struct packed {
    gate_state_t st;
    logic        fired;
  } attempt_res_t;

  // Attempt: gate on service/enable, defer in gap, else fire; periodic if active.
  function automatic attempt_res_t attempt(gate_state_t s, logic kind, logic dflt,
                                           logic running, cfg_t cfg);
    attempt_res_t r;
    r.st    = s;
    r.fired = 1'b0;
    if (running && !(kind == KIND_SPONT && !cfg.spontaneous_enable)) begin
      if (cfg.min_gap_ms != '0 && s.since_last_fire < cfg.min_gap_ms) begin
        if (s.deferred_valid) begin
          if (kind == KIND_SPONT) r.st.deferred_kind = KIND_SPONT;
        end else begin
          r.st.deferred_valid = 1'b1;
          r.st.deferred_kind  = kind;
        end
      end else begin
        r.fired = 1'b1;
        if (cfg.send_only_if_active) begin
          if (dflt) begin
            if (s.inactive_count < INACTIVE_SAT) begin
              r.st.inactive_count = s.inactive_count + 2'd1;
            end
          end else begin
            r.st.inactive_count = '0;
          end
          if (kind == KIND_PERIODIC && r.st.inactive_count > INACTIVE_LIMIT) begin
            r.fired = 1'b0;
          end
        end
        if (r.fired) r.st.since_last_fire = '0;
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ttrg_step.sv -----
// Next-state and result logic for one tick or spontaneous request.
module ttrg_step import ttrg_pkg::*; (
  input  cfg_t        cfg,
  input  gate_state_t state_cur,
  input  in_item_t    item,
  output gate_state_t state_next,
  output out_item_t   result
);

  attempt_res_t def_res;
  attempt_res_t per_res;
  attempt_res_t sp_res;
  gate_state_t  s;
  logic         fired;
  logic         kind;
  logic         job_kind;

  always_comb begin
    s        = state_cur;
    fired    = 1'b0;
    kind     = KIND_PERIODIC;
    job_kind = state_cur.deferred_kind;
    sp_res   = attempt(s, KIND_SPONT, item.all_default, item.service_running, cfg);
    def_res  = '0;
    per_res  = '0;
    if (item.opcode == OP_SPONT) begin
      s     = sp_res.st;
      fired = sp_res.fired;
      kind  = KIND_SPONT;
    end else begin
      // Advance time first.
      if (s.since_last_fire != MS_MAX) s.since_last_fire = s.since_last_fire + 16'd1;
      // Run a due deferred job; it is consumed even if it fails.
      if (s.deferred_valid && s.since_last_fire >= cfg.min_gap_ms) begin
        s.deferred_valid = 1'b0;
        s.deferred_kind  = KIND_PERIODIC;
        def_res = attempt(s, job_kind, item.all_default, item.service_running, cfg);
        s       = def_res.st;
        if (def_res.fired) begin
          fired = 1'b1;
          kind  = job_kind;
        end
      end
      if (cfg.cycle_time_ms != '0) begin
        s.period_phase = s.period_phase + 16'd1;
        if (s.period_phase >= cfg.cycle_time_ms) begin
          s.period_phase = '0;
          per_res = attempt(s, KIND_PERIODIC, item.all_default, item.service_running, cfg);
          s       = per_res.st;
          if (per_res.fired) begin
            if (!fired) kind = KIND_PERIODIC;
            fired = 1'b1;
          end
        end
      end else begin
        s.period_phase = '0;
      end
    end
    state_next       = s;
    result.fire      = fired;
    result.fire_kind = fired & kind;
    result.pending   = s.deferred_valid;
  end

endmodule

// ----- hw/rtl/tx_trigger_rate_gate_core.sv -----
// Transmit trigger rate gate: input register, gate logic, result register.
// Each item passes the input register, then the result register. Throughput: one
// item per cycle while the output is not stalled; the gate state updates in the
// same cycle an item moves from the input register into the result register.
// Reset (rst_n low, synchronous): config, valid flags and gate state cleared,
// since_last_fire saturated, both channels empty; data registers not reset.
`include "tx_trigger_rate_gate_core_macros.svh"

module tx_trigger_rate_gate_core import ttrg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg_r;
  gate_state_t state_r;
  gate_state_t state_nxt;
  in_item_t    in_data_r;
  logic        in_valid_r;
  out_item_t   out_data_r;
  out_item_t   result;
  logic        out_valid_r;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ttrg_step u_step (
    .cfg        (cfg_r),
    .state_cur  (state_r),
    .item       (in_data_r),
    .state_next (state_nxt),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_CYCLE_TIME:  cfg_r.cycle_time_ms       <= cfg_data;
        CFG_IDX_MIN_GAP:     cfg_r.min_gap_ms          <= cfg_data;
        CFG_IDX_SPONT_EN:    cfg_r.spontaneous_enable  <= cfg_data[0];
        CFG_IDX_ONLY_ACTIVE: cfg_r.send_only_if_active <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{period_phase: '0, since_last_fire: MS_MAX, deferred_valid: 1'b0,
                       deferred_kind: 1'b0, inactive_count: '0};
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (advance) out_valid_r <= in_valid_r;
      // Commit the state only when the transaction moves on.
      if (advance && in_valid_r) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (advance && in_valid_r) out_data_r <= result;
  end

  `TTRG_ASSERT_NEXT(a_item_reaches_output, in_valid_r && advance, out_valid_r)
  `TTRG_ASSERT_NOW(a_inactive_saturates, 1'b1, state_r.inactive_count != 2'd3)
  `TTRG_ASSERT_NOW(a_idle_job_kind_clear, !state_r.deferred_valid, !state_r.deferred_kind)

endmodule
